>>> rtl/rssh_pkg.sv
`timescale 1ns / 1ps
package rssh_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int RAD_BITS        = COORD_BITS - 1;
  localparam int DIFF_BITS       = COORD_BITS + 1;
  localparam int PROD_BITS       = 2 * DIFF_BITS;
  localparam int SUM_BITS        = PROD_BITS + 2;
  localparam int DISC_BITS       = 2 * SUM_BITS;
  localparam int PARAM_BITS      = PARAM_FRAC_BITS + 1;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_MISS   = 2'd0,
    ST_INSIDE = 2'd1,
    ST_ENTER  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic signed [COORD_BITS-1:0] centre_z;
    logic        [RAD_BITS-1:0]   sphere_radius;
  } in_t;

  typedef struct packed {
    logic [1:0]            hit_status;
    logic [PARAM_BITS-1:0] hit_param;
  } out_t;

  // classified query handed from front to back
  typedef struct packed {
    logic                start_in;
    logic                live;
    logic [SUM_BITS-1:0] a;
    logic [SUM_BITS-1:0] m;
    logic [SUM_BITS-1:0] c;
  } work_t;

  typedef struct packed {
    logic                  start_in;
    logic                  live;
    logic [SUM_BITS-1:0]   a;
    logic [SUM_BITS-1:0]   m;
    logic [SUM_BITS-1:0]   c;
    logic [DISC_BITS-1:0]  m2;
    logic [DISC_BITS-1:0]  ac;
    logic [DISC_BITS-1:0]  rem;
    logic [SUM_BITS-1:0]   root;
    logic [SUM_BITS-1:0]   n;
    logic [SUM_BITS:0]     dq;
    logic [PARAM_BITS-1:0] quo;
  } pipe_t;

endpackage

>>> rtl/ray_segment_sphere_hit_core.sv
`timescale 1ns / 1ps
// segment-sphere first-entry query: one query per beat in, one result per beat out, one beat
// per clock sustained when neither side stalls. the front pipe (3 stages: differences, 17x17
// products, dot-product sums, with classification on the sums) decides start-inside and
// certain misses and pushes each query into a 4-entry queue; the back pipe takes one queue
// entry per clock, unless the queue is empty or the output stalls, through a 36x36 multiply,
// the discriminant, a one-bit-per-stage integer square root (36 stages), root selection and a
// one-bit-per-stage restoring divide (17 stages), then an output register.
// throughput is one query per clock when neither side stalls.
// result hit_status: 0 miss, 1 start strictly inside, 2 segment enters; hit_param is the
// entry parameter in unsigned q1.16, truncated, zero unless status is 2
module ray_segment_sphere_hit_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rssh_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rssh_pkg::out_t out_data
);

  // front to queue
  logic            q_full;
  logic            q_push;
  rssh_pkg::work_t q_wdata;

  // queue to back
  logic            q_empty;
  logic            q_pop;
  rssh_pkg::work_t q_rdata;

  // front: classify each query, stalls only when the queue is full
  rssh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // short queue decoupling the two pipes
  rssh_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back: root and divide pipe, held by the output stall
  rssh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/rssh_front.sv
`timescale 1ns / 1ps
module rssh_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rssh_pkg::in_t        in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output rssh_pkg::work_t      q_data
);

  localparam int DW = rssh_pkg::DIFF_BITS;
  localparam int PW = rssh_pkg::PROD_BITS;
  localparam int SW = rssh_pkg::SUM_BITS;
  localparam int RW = rssh_pkg::RAD_BITS;

  logic en;
  logic v1, v2, v3;
  logic signed [DW-1:0] st [3];
  logic signed [DW-1:0] dr [3];
  logic [RW-1:0] rad;
  logic signed [PW-1:0] dd [3];
  logic signed [PW-1:0] ss [3];
  logic signed [PW-1:0] ds [3];
  logic [2*RW-1:0] r2, r2b;
  logic [SW-1:0] a, q;
  logic signed [SW:0] h;
  logic signed [DW-1:0] st_n [3];
  logic signed [DW-1:0] dr_n [3];
  logic [SW-1:0] r2w;

  assign en       = !v3 || !q_full;
  assign in_stall = !en;
  assign q_push   = v3 && en;

  always_comb begin
    st_n[0] = DW'(in_data.start_x) - DW'(in_data.centre_x);
    st_n[1] = DW'(in_data.start_y) - DW'(in_data.centre_y);
    st_n[2] = DW'(in_data.start_z) - DW'(in_data.centre_z);
    dr_n[0] = DW'(in_data.end_x) - DW'(in_data.start_x);
    dr_n[1] = DW'(in_data.end_y) - DW'(in_data.start_y);
    dr_n[2] = DW'(in_data.end_z) - DW'(in_data.start_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        st[k] <= st_n[k];
        dr[k] <= dr_n[k];
        dd[k] <= PW'(dr[k]) * PW'(dr[k]);
        ss[k] <= PW'(st[k]) * PW'(st[k]);
        ds[k] <= PW'(dr[k]) * PW'(st[k]);
      end
      rad <= in_data.sphere_radius;
      r2  <= (2*RW)'(rad) * (2*RW)'(rad);
      a   <= SW'(unsigned'(dd[0])) + SW'(unsigned'(dd[1])) + SW'(unsigned'(dd[2]));
      q   <= SW'(unsigned'(ss[0])) + SW'(unsigned'(ss[1])) + SW'(unsigned'(ss[2]));
      h   <= (SW+1)'(ds[0]) + (SW+1)'(ds[1]) + (SW+1)'(ds[2]);
      r2b <= r2;
    end
  end

  // classify: start inside, certain miss, or needs the root
  always_comb begin
    r2w             = SW'(r2b);
    q_data.start_in = q < r2w;
    q_data.live     = !(q < r2w) && (a != '0) && h[SW];
    q_data.a        = a;
    q_data.m        = SW'(-h);
    q_data.c        = q - r2w;
  end

endmodule

>>> rtl/rssh_fifo.sv
`timescale 1ns / 1ps
module rssh_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rssh_pkg::work_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rssh_pkg::work_t rdata
);

  localparam int AW = rssh_pkg::QUEUE_AW;

  rssh_pkg::work_t mem [rssh_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full  = cnt == (AW+1)'(rssh_pkg::QUEUE_DEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule

>>> rtl/rssh_back.sv
`timescale 1ns / 1ps
module rssh_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  rssh_pkg::work_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output rssh_pkg::out_t  out_data
);

  localparam int SW  = rssh_pkg::SUM_BITS;
  localparam int XW  = rssh_pkg::DISC_BITS;
  localparam int QW  = rssh_pkg::PARAM_BITS;
  localparam int SEL = 2 + SW;
  localparam int NG  = SEL + 1 + QW;

  logic en;
  rssh_pkg::pipe_t pl [NG+1];
  rssh_pkg::pipe_t nx [NG];
  logic [NG:0] vld;

  assign en    = !out_valid || !out_stall;
  assign q_pop = en && !q_empty;

  always_comb begin
    pl[0]          = '0;
    pl[0].start_in = q_data.start_in;
    pl[0].live     = q_data.live;
    pl[0].a        = q_data.a;
    pl[0].m        = q_data.m;
    pl[0].c        = q_data.c;
  end
  assign vld[0] = !q_empty;

  for (genvar g = 0; g < NG; g++) begin : g_stage
    if (g == 0) begin : g_mul
      always_comb begin
        nx[g]    = pl[g];
        nx[g].m2 = XW'(pl[g].m) * XW'(pl[g].m);
        nx[g].ac = XW'(pl[g].a) * XW'(pl[g].c);
      end
    end else if (g == 1) begin : g_disc
      always_comb begin
        nx[g]      = pl[g];
        nx[g].rem  = pl[g].m2 - pl[g].ac;
        nx[g].root = '0;
        if (pl[g].m2 < pl[g].ac) nx[g].live = 1'b0;
      end
    end else if (g < SEL) begin : g_sqrt
      localparam int BI = SW - 1 - (g - 2);
      logic [XW:0] tr;
      always_comb begin
        tr = ((XW+1)'(pl[g].root) << (BI + 1)) | ((XW+1)'(1) << (2 * BI));
        nx[g] = pl[g];
        if ((XW+1)'(pl[g].rem) >= tr) begin
          nx[g].rem  = XW'((XW+1)'(pl[g].rem) - tr);
          nx[g].root = pl[g].root | (SW'(1) << BI);
        end
      end
    end else if (g == SEL) begin : g_pick
      logic [SW:0] n1, n0, aw;
      always_comb begin
        n1 = (SW+1)'(pl[g].m) + (SW+1)'(pl[g].root);
        n0 = (SW+1)'(pl[g].m) - (SW+1)'(pl[g].root);
        aw = (SW+1)'(pl[g].a);
        nx[g]     = pl[g];
        nx[g].quo = '0;
        nx[g].n   = '0;
        if (n1 <= aw) begin
          // near root when it is positive, else the far one
          nx[g].n = (!n0[SW] && n0 != '0) ? SW'(n0) : SW'(n1);
        end else if (!n0[SW] && n0 != '0 && n0 <= aw) begin
          nx[g].n = SW'(n0);
        end else begin
          nx[g].live = 1'b0;
        end
      end
    end else begin : g_div
      logic [SW:0] rr;
      logic        bit_q;
      always_comb begin
        rr    = (g == SEL + 1) ? (SW+1)'(pl[g].n) : {pl[g].dq[SW-1:0], 1'b0};
        bit_q = rr >= (SW+1)'(pl[g].a);
        nx[g]     = pl[g];
        nx[g].dq  = bit_q ? rr - (SW+1)'(pl[g].a) : rr;
        nx[g].quo = {pl[g].quo[QW-2:0], bit_q};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else if (en) vld[g+1] <= vld[g];
    end

    always_ff @(posedge clk) begin
      if (en) pl[g+1] <= nx[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[NG];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pl[NG].start_in) begin
        out_data.hit_status <= rssh_pkg::ST_INSIDE;
        out_data.hit_param  <= '0;
      end else if (pl[NG].live) begin
        out_data.hit_status <= rssh_pkg::ST_ENTER;
        out_data.hit_param  <= pl[NG].quo;
      end else begin
        out_data.hit_status <= rssh_pkg::ST_MISS;
        out_data.hit_param  <= '0;
      end
    end
  end

endmodule
